// ----- design/rluq_pkg.sv -----
// ----------------------------------------------------------------------------
// Rate limited update queue package
// Shared widths, defaults, action and status codes and the sequencer states.
// ----------------------------------------------------------------------------
package rluq_pkg;

  // Default values of the top level parameters.
  localparam int NUM_CHANNELS_DEF = 16;
  localparam int TIME_BITS_DEF    = 32;

  // Fixed field widths of the item and result ports.
  localparam int ACTION_W  = 3;
  localparam int CHANNEL_W = 4;
  localparam int TYPE_W    = 16;
  localparam int DELAY_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int READY_W   = 4;
  localparam int HINT_W    = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 3'd0,
    ACT_UPDATE = 3'd1,
    ACT_TAKE   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_CONFIG = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NONE    = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_SCAN,
    S_POP_RD,
    S_POP_CH,
    S_POP_WR
  } state_e;

endpackage

// ----- design/rate_limited_update_queue_core.sv -----
// ----------------------------------------------------------------------------
// Rate limited update queue core
// Coalesces update events per channel and hands out due channels in FIFO
// order, each channel with its own minimum gap between deliveries.
// ----------------------------------------------------------------------------
// Tick, update, configure, rejected items and clear of an unqueued channel end in the
// decode step. Take scans every channel through the one channel memory read port, then
// pops the FIFO head if there is one. Clear of a queued channel compacts the job FIFO one
// entry per cycle. busy drops in the done_o cycle, so the next item can be taken at the
// edge that ends it. Reset clears clock and flags at once.
module rate_limited_update_queue_core
  import rluq_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [CHANNEL_W-1:0] channel_i,
  input  logic [TYPE_W-1:0]    type_bits_i,
  input  logic [DELAY_W-1:0]   min_delay_i,
  output logic                 done_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [READY_W-1:0]   ready_channel_o,
  output logic [HINT_W-1:0]    wait_hint_o
);

  // Channel index width; the job FIFO is a ring of the next power of two.
  localparam int CH_W   = $clog2(NUM_CHANNELS);
  localparam int FD     = 1 << CH_W;
  localparam int CNT_W  = CH_W + 1;
  localparam int CMP_W  = (TIME_BITS > HINT_W) ? TIME_BITS : HINT_W;
  localparam int WORD_W = TYPE_W + DELAY_W + TIME_BITS;
  localparam int CHX_W  = CH_W + CHANNEL_W;

  // Sequencer and item registers.
  state_e              state_q, state_d;
  logic [ACTION_W-1:0] act_q, act_d;
  logic [CH_W-1:0]     ch_q, ch_d;
  logic                inr_q, inr_d;
  logic [TYPE_W-1:0]   bits_q, bits_d;
  logic [DELAY_W-1:0]  mdel_q, mdel_d;

  // Kept state. The flags live in flip-flops so that reset clears them;
  // mask, delay and wakeup of a channel are read only once it is subscribed.
  logic [TIME_BITS-1:0]    now_q, now_d;
  logic [NUM_CHANNELS-1:0] sub_q, sub_d;
  logic [NUM_CHANNELS-1:0] pend_q, pend_d;
  logic [NUM_CHANNELS-1:0] queu_q, queu_d;
  logic [CH_W-1:0]         head_q, head_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  // Scan and compaction counters.
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  wr_q, wr_d;
  logic              rv_q, rv_d;
  logic [CH_W-1:0]   sidx_q, sidx_d;
  logic [HINT_W-1:0] best_q, best_d;

  // Result registers.
  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [READY_W-1:0]  ready_q, ready_d;
  logic [HINT_W-1:0]   hint_q, hint_d;

  // Channel memory: {type mask, delay, wakeup}, one read and one write port.
  logic [WORD_W-1:0] chan_mem [FD];
  logic [WORD_W-1:0] chan_rd_q;
  logic [CH_W-1:0]   chan_raddr, chan_waddr;
  logic [WORD_W-1:0] chan_wdata;
  logic              chan_we;

  // Job FIFO memory holding channel numbers.
  logic [CH_W-1:0] fifo_mem [FD];
  logic [CH_W-1:0] fifo_rd_q;
  logic [CH_W-1:0] fifo_raddr, fifo_waddr, fifo_wdata;
  logic            fifo_we;

  // Decoded input channel and fields of the channel memory read word.
  logic [CHX_W-1:0]     ch_wide;
  logic [CH_W-1:0]      ch_idx;
  logic                 in_range;
  logic [TYPE_W-1:0]    rd_mask;
  logic [DELAY_W-1:0]   rd_delay;
  logic [TIME_BITS-1:0] rd_wake;
  logic [CH_W-1:0]      tail;
  logic [CHX_W-1:0]     v_wide;

  // Shared time unit.
  logic [DELAY_W-1:0]   tu_delta;
  logic [TIME_BITS-1:0] tu_left, tu_sum;
  logic                 tu_due;
  logic [CMP_W-1:0]     left_ext, best_ext;

  logic accept;
  logic scan_more, clr_more, clr_end;

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);

  assign ch_wide  = {{CH_W{1'b0}}, channel_i};
  assign ch_idx   = ch_wide[CH_W-1:0];
  assign in_range = ch_wide < CHX_W'(NUM_CHANNELS);

  assign rd_mask  = chan_rd_q[WORD_W-1 -: TYPE_W];
  assign rd_delay = chan_rd_q[TIME_BITS +: DELAY_W];
  assign rd_wake  = chan_rd_q[TIME_BITS-1:0];
  assign tail     = head_q + cnt_q[CH_W-1:0];
  assign v_wide   = {{CHANNEL_W{1'b0}}, sidx_q};

  // Configure adds the new minimum gap; a pop adds the stored one.
  assign tu_delta = (act_q == ACT_CONFIG) ? mdel_q : rd_delay;
  assign left_ext = CMP_W'(tu_left);
  assign best_ext = CMP_W'(best_q);

  assign scan_more = idx_q < CNT_W'(NUM_CHANNELS);
  assign clr_more  = idx_q < cnt_q;
  assign clr_end   = !clr_more && !rv_q;

  rluq_time_unit #(
    .TIME_BITS(TIME_BITS)
  ) u_time (
    .now_i  (now_q),
    .wake_i (rd_wake),
    .delay_i(rd_delay),
    .delta_i(tu_delta),
    .left_o (tu_left),
    .due_o  (tu_due),
    .sum_o  (tu_sum)
  );

  // Memories: synchronous write, registered read.
  always_ff @(posedge clk_i) begin
    if (chan_we) begin
      chan_mem[chan_waddr] <= chan_wdata;
    end
    chan_rd_q <= chan_mem[chan_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    fifo_rd_q <= fifo_mem[fifo_raddr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (act_q == ACT_TAKE) begin
          state_d = S_SCAN;
        end else if ((act_q == ACT_CLEAR) && inr_q && sub_q[ch_q] && queu_q[ch_q]) begin
          state_d = S_CLEAR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (clr_end) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!scan_more && !rv_q) begin
          state_d = S_POP_RD;
        end
      end
      S_POP_RD: begin
        state_d = (cnt_q == '0) ? S_IDLE : S_POP_CH;
      end
      S_POP_CH: state_d = S_POP_WR;
      S_POP_WR: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    act_d    = act_q;
    ch_d     = ch_q;
    inr_d    = inr_q;
    bits_d   = bits_q;
    mdel_d   = mdel_q;
    now_d    = now_q;
    sub_d    = sub_q;
    pend_d   = pend_q;
    queu_d   = queu_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    wr_d     = wr_q;
    rv_d     = rv_q;
    sidx_d   = sidx_q;
    best_d   = best_q;
    done_d   = 1'b0;
    status_d = status_q;
    ready_d  = ready_q;
    hint_d   = hint_q;

    chan_raddr = ch_idx;
    chan_waddr = ch_q;
    chan_wdata = {bits_q, mdel_q, tu_sum};
    chan_we    = 1'b0;
    fifo_raddr = head_q;
    fifo_waddr = tail;
    fifo_wdata = ch_q;
    fifo_we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        // The channel word is read on the accepting edge for the decode step.
        if (accept) begin
          act_d  = action_i;
          ch_d   = ch_idx;
          inr_d  = in_range;
          bits_d = type_bits_i;
          mdel_d = min_delay_i;
        end
      end

      S_DECODE: begin
        done_d   = 1'b1;
        status_d = STAT_OK;
        ready_d  = '0;
        hint_d   = '0;
        unique case (act_q)
          ACT_TICK: begin
            now_d = now_q + 1'b1;
          end
          ACT_UPDATE: begin
            if (!inr_q) begin
              status_d = STAT_UNKNOWN;
            end else if (!sub_q[ch_q] || ((rd_mask & bits_q) == '0)) begin
              status_d = STAT_IGNORED;
            end else begin
              pend_d[ch_q] = 1'b1;
              if (tu_due && !queu_q[ch_q]) begin
                fifo_we      = 1'b1;
                cnt_d        = cnt_q + 1'b1;
                queu_d[ch_q] = 1'b1;
              end
            end
          end
          ACT_TAKE: begin
            done_d = 1'b0;
            idx_d  = '0;
            rv_d   = 1'b0;
            best_d = '1;
          end
          ACT_CLEAR: begin
            if (!inr_q || !sub_q[ch_q]) begin
              status_d = STAT_UNKNOWN;
            end else begin
              pend_d[ch_q] = 1'b0;
              queu_d[ch_q] = 1'b0;
              if (queu_q[ch_q]) begin
                // The channel sits in the FIFO: compact it out first.
                done_d = 1'b0;
                idx_d  = '0;
                wr_d   = '0;
                rv_d   = 1'b0;
              end
            end
          end
          ACT_CONFIG: begin
            if (!inr_q) begin
              status_d = STAT_UNKNOWN;
            end else if (sub_q[ch_q]) begin
              status_d = STAT_IGNORED;
            end else begin
              sub_d[ch_q]  = 1'b1;
              pend_d[ch_q] = 1'b0;
              queu_d[ch_q] = 1'b0;
              chan_we      = 1'b1;
            end
          end
          default: begin
            status_d = STAT_IGNORED;
          end
        endcase
      end

      S_CLEAR: begin
        // Read one entry a cycle and write back every entry that is kept.
        // The write slot never passes the read slot, so nothing is lost.
        if (clr_more) begin
          fifo_raddr = head_q + idx_q[CH_W-1:0];
          rv_d       = 1'b1;
          idx_d      = idx_q + 1'b1;
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q && (fifo_rd_q != ch_q)) begin
          fifo_we    = 1'b1;
          fifo_waddr = head_q + wr_q[CH_W-1:0];
          fifo_wdata = fifo_rd_q;
          wr_d       = wr_q + 1'b1;
        end
        if (clr_end) begin
          cnt_d    = wr_q;
          done_d   = 1'b1;
          status_d = STAT_OK;
          ready_d  = '0;
          hint_d   = '0;
        end
      end

      S_SCAN: begin
        // One channel read per cycle; the registered word arrives in the next cycle.
        if (scan_more) begin
          chan_raddr = idx_q[CH_W-1:0];
          sidx_d     = idx_q[CH_W-1:0];
          rv_d       = 1'b1;
          idx_d      = idx_q + 1'b1;
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q && sub_q[sidx_q]) begin
          if (tu_due) begin
            if (pend_q[sidx_q] && !queu_q[sidx_q]) begin
              fifo_we        = 1'b1;
              fifo_wdata     = sidx_q;
              cnt_d          = cnt_q + 1'b1;
              queu_d[sidx_q] = 1'b1;
            end
          end else if (left_ext < best_ext) begin
            best_d = left_ext[HINT_W-1:0];
          end
        end
      end

      S_POP_RD: begin
        fifo_raddr = head_q;
        if (cnt_q == '0) begin
          done_d   = 1'b1;
          status_d = STAT_NONE;
          ready_d  = '0;
          hint_d   = best_q;
        end
      end

      S_POP_CH: begin
        chan_raddr = fifo_rd_q;
        sidx_d     = fifo_rd_q;
      end

      S_POP_WR: begin
        pend_d[sidx_q] = 1'b0;
        queu_d[sidx_q] = 1'b0;
        if (rd_delay != '0) begin
          chan_we    = 1'b1;
          chan_waddr = sidx_q;
          chan_wdata = {rd_mask, rd_delay, tu_sum};
        end
        head_d   = head_q + 1'b1;
        cnt_d    = cnt_q - 1'b1;
        done_d   = 1'b1;
        status_d = STAT_OK;
        ready_d  = v_wide[READY_W-1:0];
        hint_d   = best_q;
      end

      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      now_q   <= '0;
      sub_q   <= '0;
      pend_q  <= '0;
      queu_q  <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      sub_q   <= sub_d;
      pend_q  <= pend_d;
      queu_q  <= queu_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    ch_q     <= ch_d;
    inr_q    <= inr_d;
    bits_q   <= bits_d;
    mdel_q   <= mdel_d;
    idx_q    <= idx_d;
    wr_q     <= wr_d;
    sidx_q   <= sidx_d;
    best_q   <= best_d;
    status_q <= status_d;
    ready_q  <= ready_d;
    hint_q   <= hint_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign ready_channel_o = ready_q;
  assign wait_hint_o     = hint_q;

endmodule

// ----- design/rluq_time_unit.sv -----
// ----------------------------------------------------------------------------
// Rate limited update queue time unit
// Shared modular time compare and wakeup adder used by the update, configure, scan and pop steps.
// ----------------------------------------------------------------------------
module rluq_time_unit
  import rluq_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] wake_i,
  input  logic [DELAY_W-1:0]   delay_i,
  input  logic [DELAY_W-1:0]   delta_i,
  output logic [TIME_BITS-1:0] left_o,
  output logic                 due_o,
  output logic [TIME_BITS-1:0] sum_o
);

  // The channel is due when its delay is zero or when now minus wakeup lies in the lower
  // half range, which is the same as the time left being zero or above half range.
  assign left_o = wake_i - now_i;
  assign due_o  = (delay_i == '0) || (left_o == '0) ||
                  (left_o[TIME_BITS-1] && (left_o[TIME_BITS-2:0] != '0));
  assign sum_o  = now_i + TIME_BITS'(delta_i);

endmodule
